>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: post must hold whenever pre holds.
`define FNB_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("four-neighbor blur check failed");

// Next-cycle implication: post must hold in the cycle after pre.
`define FNB_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("four-neighbor blur check failed");

`endif

>>> hdl/fnb_pkg.sv
// ----------------------------------------------------------------------------
// fnb_pkg
// Shared types and constants of the four-neighbor RGB blur.
// ----------------------------------------------------------------------------
package fnb_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int WEFF_W     = ADDR_W + 1;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int PIX_W      = CH_W * NUM_CH;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_TAPS   = 2;

    localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 16'd768;

    typedef logic [PIX_W-1:0] pixel_t;

    // One line store entry: row y-1 pixel and row y-2 pixel of one column
    typedef struct packed {
        pixel_t mid;
        pixel_t up;
    } line_entry_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } cfg_reg_t;

    // Control carried with an item from the tap stage to the output stage
    typedef struct packed {
        logic has_a;
        logic border;
        logic last_row;
        logic last_col;
    } s1_ctl_t;

endpackage

>>> hdl/four_neighbour_rgb_blur.sv
// ----------------------------------------------------------------------------
// four_neighbour_rgb_blur
// Streaming four-neighbor average blur of a raster-order RGB frame.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in      | sink      | in_valid/in_stall  | in_red, in_green, in_blue
//  out     | source    | out_valid/out_stall| out_red/green/blue, run_last,
//          |           |                    | frame_last
//  cfg     | sink      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One pixel is taken per clock unless in_stall holds it; each produces zero,
//  one or two results, so on the last row the single output port holds back input.
//  A pixel is registered in stage 1, then in the stage 2 output register.
//  Reset clears counters and pipeline valids; the line store is not cleared.
//  An output stall backs up through the output stage into in_stall
//  in the same cycle; the line store read port is held while a pixel waits.
//
module four_neighbour_rgb_blur (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [fnb_pkg::CH_W-1:0]          in_red,
    input  logic [fnb_pkg::CH_W-1:0]          in_green,
    input  logic [fnb_pkg::CH_W-1:0]          in_blue,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [fnb_pkg::CH_W-1:0]          out_red,
    output logic [fnb_pkg::CH_W-1:0]          out_green,
    output logic [fnb_pkg::CH_W-1:0]          out_blue,
    output logic                              run_last,
    output logic                              frame_last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fnb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fnb_pkg::CFG_DATA_W-1:0]    cfg_data
);

`include "assert_macros.svh"

    // ------------------------------------------------------------------
    // Configuration registers and effective frame size
    // ------------------------------------------------------------------
    logic [fnb_pkg::IMG_W_W-1:0] width_reg;
    logic [fnb_pkg::IMG_W_W-1:0] width_next;
    logic [fnb_pkg::IMG_H_W-1:0] height_reg;
    logic [fnb_pkg::IMG_H_W-1:0] height_next;
    logic                        cfg_xfer;
    logic                        cfg_hit;

    logic [fnb_pkg::WEFF_W-1:0]  w_eff;
    logic [fnb_pkg::IMG_H_W-1:0] h_eff;

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        cfg_hit     = 1'b0;
        if (cfg_xfer)
        begin
            case (fnb_pkg::cfg_reg_t'(cfg_index))
                fnb_pkg::REG_IMAGE_WIDTH:
                begin
                    width_next = cfg_data[fnb_pkg::IMG_W_W-1:0];
                    cfg_hit    = 1'b1;
                end
                fnb_pkg::REG_IMAGE_HEIGHT:
                begin
                    height_next = cfg_data[fnb_pkg::IMG_H_W-1:0];
                    cfg_hit     = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // Clamp width into [1, MAX_WIDTH], height zero counts as one
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = fnb_pkg::WEFF_W'(1);
        end
        else if (32'(width_reg) > 32'(fnb_pkg::MAX_WIDTH))
        begin
            w_eff = fnb_pkg::WEFF_W'(fnb_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = fnb_pkg::WEFF_W'(width_reg);
        end
        h_eff = (height_reg == '0) ? fnb_pkg::IMG_H_W'(1) : height_reg;
    end

    // ------------------------------------------------------------------
    // Handshake and stage control
    // ------------------------------------------------------------------
    logic                 in_xfer;
    logic                 out_xfer;
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    fnb_pkg::s1_ctl_t     s1_ctl_reg;
    fnb_pkg::s1_ctl_t     s1_ctl_next;
    logic                 s1_has_out;
    logic                 s1_done;
    logic                 s1_free;
    logic                 s2_can;
    logic                 s2_load;
    logic                 a_pend_reg;
    logic                 a_pend_next;
    logic                 b_pend_reg;
    logic                 b_pend_next;

    assign in_xfer    = in_valid && !in_stall;
    assign out_xfer   = out_valid && !out_stall;
    assign s1_has_out = s1_ctl_reg.has_a || s1_ctl_reg.last_row;
    // Output stage frees when empty or when its final result transfers
    assign s2_can     = !(a_pend_reg || b_pend_reg)
                        || (out_xfer && !(a_pend_reg && b_pend_reg));
    assign s1_done    = s1_valid_reg && (!s1_has_out || s2_can);
    assign s1_free    = !s1_valid_reg || s1_done;
    assign s2_load    = s1_done && s1_has_out;
    assign in_stall   = !s1_free;

    // ------------------------------------------------------------------
    // Raster position
    // ------------------------------------------------------------------
    logic [fnb_pkg::ADDR_W-1:0]  x_reg;
    logic [fnb_pkg::ADDR_W-1:0]  x_next;
    logic [fnb_pkg::IMG_H_W-1:0] y_reg;
    logic [fnb_pkg::IMG_H_W-1:0] y_next;
    logic                        last_col;
    logic                        last_row;
    logic [fnb_pkg::ADDR_W-1:0]  next_col;

    assign last_col = ({1'b0, x_reg} + fnb_pkg::WEFF_W'(1)) >= w_eff;
    assign last_row = ({1'b0, y_reg} + (fnb_pkg::IMG_H_W+1)'(1)) >= {1'b0, h_eff};
    assign next_col = last_col ? '0 : x_reg + fnb_pkg::ADDR_W'(1);

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        if (cfg_hit)
        begin
            // Any register write restarts the frame
            x_next = '0;
            y_next = '0;
        end
        else if (in_xfer)
        begin
            x_next = next_col;
            if (last_col)
            begin
                y_next = last_row ? '0 : y_reg + fnb_pkg::IMG_H_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Line store: entry x = {row y-1, row y-2}; read one column ahead
    // ------------------------------------------------------------------
    fnb_pkg::pixel_t      in_pix;
    fnb_pkg::line_entry_t ram_rdata;
    fnb_pkg::line_entry_t ram_wdata;
    fnb_pkg::line_entry_t cur_entry;
    fnb_pkg::line_entry_t fwd_data_reg;
    logic                 fwd_reg;

    assign in_pix = {in_red, in_green, in_blue};

    fnb_ram #(
        .WIDTH ($bits(fnb_pkg::line_entry_t)),
        .DEPTH (fnb_pkg::MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (in_xfer),
        .waddr (x_reg),
        .wdata (ram_wdata),
        .re    (in_xfer),
        .raddr (next_col),
        .rdata (ram_rdata)
    );

    // A one-column row reads the entry it writes in the same cycle: bypass it
    assign cur_entry = fwd_reg ? fwd_data_reg : ram_rdata;
    assign ram_wdata = '{mid: in_pix, up: cur_entry.mid};

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            fwd_data_reg <= ram_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Window taps: tap 0 is the centre column, tap 1 the left column
    // ------------------------------------------------------------------
    fnb_pkg::pixel_t tap_d [fnb_pkg::NUM_TAPS];
    fnb_pkg::pixel_t tap_q [fnb_pkg::NUM_TAPS];

    assign tap_d[0] = cur_entry.mid;

    for (genvar t = 0; t < fnb_pkg::NUM_TAPS; t++)
    begin : g_tap
        if (t > 0)
        begin : g_link
            assign tap_d[t] = tap_q[t-1];
        end
        fnb_cell u_cell (
            .clk   (clk),
            .shift (in_xfer),
            .d     (tap_d[t]),
            .q     (tap_q[t])
        );
    end

    // ------------------------------------------------------------------
    // Stage 1: pixel, up neighbor and flags
    // ------------------------------------------------------------------
    fnb_pkg::pixel_t s1_down_reg;
    fnb_pkg::pixel_t s1_up_reg;
    fnb_pkg::pixel_t blur_pix;
    fnb_pkg::pixel_t res_a;

    always_comb
    begin
        s1_ctl_next.has_a    = (y_reg != '0);
        s1_ctl_next.border   = (x_reg == '0) || last_col
                               || (y_reg == fnb_pkg::IMG_H_W'(1));
        s1_ctl_next.last_row = last_row;
        s1_ctl_next.last_col = last_col;
        s1_valid_next        = in_xfer ? 1'b1 : (s1_done ? 1'b0 : s1_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_down_reg <= in_pix;
            s1_up_reg   <= cur_entry.up;
        end
    end

    // Right neighbor is the read-ahead entry, held while stage 1 waits
    fnb_avg u_avg (
        .left  (tap_q[1]),
        .right (cur_entry.mid),
        .up    (s1_up_reg),
        .down  (s1_down_reg),
        .avg   (blur_pix)
    );

    assign res_a = s1_ctl_reg.border ? tap_q[0] : blur_pix;

    // ------------------------------------------------------------------
    // Stage 2: output register holding up to two results
    // ------------------------------------------------------------------
    fnb_pkg::pixel_t a_pix_reg;
    logic            a_run_last_reg;
    fnb_pkg::pixel_t b_pix_reg;
    logic            b_frame_last_reg;
    fnb_pkg::pixel_t out_pix;

    always_comb
    begin
        a_pend_next = a_pend_reg;
        b_pend_next = b_pend_reg;
        if (s2_load)
        begin
            a_pend_next = s1_ctl_reg.has_a;
            b_pend_next = s1_ctl_reg.last_row;
        end
        else if (out_xfer)
        begin
            // Drop the result just transferred: blurred one goes first
            if (a_pend_reg)
            begin
                a_pend_next = 1'b0;
            end
            else
            begin
                b_pend_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            a_pix_reg        <= res_a;
            a_run_last_reg   <= !s1_ctl_reg.last_row;
            b_pix_reg        <= s1_down_reg;
            b_frame_last_reg <= s1_ctl_reg.last_col;
        end
    end

    assign out_valid  = a_pend_reg || b_pend_reg;
    assign out_pix    = a_pend_reg ? a_pix_reg : b_pix_reg;
    assign run_last   = a_pend_reg ? a_run_last_reg : 1'b1;
    assign frame_last = a_pend_reg ? 1'b0 : b_frame_last_reg;
    assign out_red    = out_pix[2*fnb_pkg::CH_W +: fnb_pkg::CH_W];
    assign out_green  = out_pix[fnb_pkg::CH_W +: fnb_pkg::CH_W];
    assign out_blue   = out_pix[0 +: fnb_pkg::CH_W];

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= fnb_pkg::WIDTH_RESET;
            height_reg   <= fnb_pkg::HEIGHT_RESET;
            x_reg        <= '0;
            y_reg        <= '0;
            fwd_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_ctl_reg   <= '0;
            a_pend_reg   <= 1'b0;
            b_pend_reg   <= 1'b0;
        end
        else
        begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            x_reg        <= x_next;
            y_reg        <= y_next;
            if (in_xfer)
            begin
                fwd_reg    <= (next_col == x_reg);
                s1_ctl_reg <= s1_ctl_next;
            end
            s1_valid_reg <= s1_valid_next;
            a_pend_reg   <= a_pend_next;
            b_pend_reg   <= b_pend_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `FNB_ASSERT_IMP(a_col_in_range, 1'b1, {1'b0, x_reg} < w_eff)
    `FNB_ASSERT_IMP(a_frame_last_ends_run, out_valid && frame_last, run_last)
    `FNB_ASSERT_IMP(a_blur_then_copy, a_pend_reg && !a_run_last_reg, b_pend_reg)
    `FNB_ASSERT_NXT(a_out_held, out_valid && out_stall, out_valid)

endmodule

>>> hdl/fnb_ram.sv
// ----------------------------------------------------------------------------
// fnb_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fnb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/fnb_cell.sv
// ----------------------------------------------------------------------------
// fnb_cell
// One window tap: holds a previous-row pixel and hands it down the chain.
// ----------------------------------------------------------------------------
module fnb_cell (
    input  logic            clk,
    input  logic            shift,
    input  fnb_pkg::pixel_t d,
    output fnb_pkg::pixel_t q
);

    fnb_pkg::pixel_t pix_reg;
    fnb_pkg::pixel_t pix_next;

    // Advance on shift, hold otherwise
    always_comb
    begin
        pix_next = shift ? d : pix_reg;
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
    end

    assign q = pix_reg;

endmodule

>>> hdl/fnb_avg.sv
// ----------------------------------------------------------------------------
// fnb_avg
// Per-channel floor average of four neighbor pixels.
// ----------------------------------------------------------------------------
module fnb_avg (
    input  fnb_pkg::pixel_t left,
    input  fnb_pkg::pixel_t right,
    input  fnb_pkg::pixel_t up,
    input  fnb_pkg::pixel_t down,
    output fnb_pkg::pixel_t avg
);

    always_comb
    begin
        logic [fnb_pkg::CH_W+1:0] sum;
        avg = '0;
        for (int c = 0; c < fnb_pkg::NUM_CH; c++)
        begin
            sum = {2'b00, left[c*fnb_pkg::CH_W +: fnb_pkg::CH_W]}
                + {2'b00, right[c*fnb_pkg::CH_W +: fnb_pkg::CH_W]}
                + {2'b00, up[c*fnb_pkg::CH_W +: fnb_pkg::CH_W]}
                + {2'b00, down[c*fnb_pkg::CH_W +: fnb_pkg::CH_W]};
            // Drop two bits: floor of the sum over four
            avg[c*fnb_pkg::CH_W +: fnb_pkg::CH_W] = sum[fnb_pkg::CH_W+1:2];
        end
    end

endmodule

>>> tb/sv/blur_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// blur_checker
// Watches the pixel, result and register channels of the four-neighbor blur,
// predicts every result from the accepted pixels and compares field by field.
// ----------------------------------------------------------------------------
module blur_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [fnb_pkg::CH_W-1:0]       in_red,
    input  logic [fnb_pkg::CH_W-1:0]       in_green,
    input  logic [fnb_pkg::CH_W-1:0]       in_blue,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [fnb_pkg::CH_W-1:0]       out_red,
    input  logic [fnb_pkg::CH_W-1:0]       out_green,
    input  logic [fnb_pkg::CH_W-1:0]       out_blue,
    input  logic                           run_last,
    input  logic                           frame_last,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [fnb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fnb_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             pending_results,
    output int                             mismatch_count
);
    import fnb_pkg::*;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            run_end;
        logic            frame_end;
    } blurred_pixel_t;

    // Row y-1 (then row y for columns already passed) and the row above it
    pixel_t               recent_row [MAX_WIDTH];
    pixel_t               earlier_row [MAX_WIDTH];
    logic [IMG_W_W-1:0]   width_reg;
    logic [IMG_H_W-1:0]   height_reg;
    int                   col_pos;
    int                   row_pos;
    int                   result_index;
    blurred_pixel_t       expected_pixels [$];

    initial
    begin
        pending_results = 0;
        mismatch_count  = 0;
        result_index    = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        begin
            $display("%0t ns: result %0d: %s is %0d, expected %0d",
                     $time, result_index, what, got, want);
            mismatch_count++;
        end
    endtask

    function automatic pixel_t four_way_mean(input pixel_t left, input pixel_t right,
                                             input pixel_t up, input pixel_t down);
        pixel_t     mean;
        logic [9:0] total;
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                total = {2'b00, left[ch*CH_W +: CH_W]} + {2'b00, right[ch*CH_W +: CH_W]} +
                        {2'b00, up[ch*CH_W +: CH_W]} + {2'b00, down[ch*CH_W +: CH_W]};
                mean[ch*CH_W +: CH_W] = total[9:2];
            end
            return mean;
        end
    endfunction

    task automatic queue_result(input pixel_t pix, input logic run_end, input logic frame_end);
        blurred_pixel_t item;
        begin
            item.red       = pix[2*CH_W +: CH_W];
            item.green     = pix[CH_W +: CH_W];
            item.blue      = pix[0 +: CH_W];
            item.run_end   = run_end;
            item.frame_end = frame_end;
            expected_pixels.push_back(item);
        end
    endtask

    // Advance the frame position by one pixel and queue what it releases
    task automatic predict_blur(input pixel_t pix);
        int     cols;
        int     rows;
        logic   last_row;
        logic   last_col;
        logic   border;
        pixel_t centre;
        begin
            cols = width_reg;
            if (cols == 0)
                cols = 1;
            if (cols > MAX_WIDTH)
                cols = MAX_WIDTH;
            rows = (height_reg == 0) ? 1 : height_reg;
            last_row = (row_pos + 1 >= rows);
            last_col = (col_pos + 1 >= cols);

            if (row_pos >= 1)
            begin
                centre = recent_row[col_pos];
                border = (col_pos == 0) || last_col || (row_pos == 1);
                if (border)
                    queue_result(centre, !last_row, 1'b0);
                else
                    queue_result(four_way_mean(earlier_row[col_pos - 1],
                                               recent_row[col_pos + 1],
                                               earlier_row[col_pos], pix),
                                 !last_row, 1'b0);
            end
            if (last_row)
                queue_result(pix, 1'b1, last_col);

            earlier_row[col_pos] = recent_row[col_pos];
            recent_row[col_pos]  = pix;

            if (last_col)
            begin
                col_pos = 0;
                row_pos = last_row ? 0 : row_pos + 1;
            end
            else
            begin
                col_pos = col_pos + 1;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        blurred_pixel_t seen;
        blurred_pixel_t want;
        if (!rst_n)
        begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            col_pos    = 0;
            row_pos    = 0;
            expected_pixels.delete();
            pending_results = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen = '{out_red, out_green, out_blue, run_last, frame_last};
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch("unexpected result, red", seen.red, 0);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (seen.red != want.red)
                        report_mismatch("out_red", seen.red, want.red);
                    if (seen.green != want.green)
                        report_mismatch("out_green", seen.green, want.green);
                    if (seen.blue != want.blue)
                        report_mismatch("out_blue", seen.blue, want.blue);
                    if (seen.run_end != want.run_end)
                        report_mismatch("run_last", seen.run_end, want.run_end);
                    if (seen.frame_end != want.frame_end)
                        report_mismatch("frame_last", seen.frame_end, want.frame_end);
                end
                result_index++;
            end

            // Any register write restarts the frame; the line stores keep their data
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_IMAGE_WIDTH:
                    begin
                        width_reg = cfg_data[IMG_W_W-1:0];
                        col_pos   = 0;
                        row_pos   = 0;
                    end
                    REG_IMAGE_HEIGHT:
                    begin
                        height_reg = cfg_data[IMG_H_W-1:0];
                        col_pos    = 0;
                        row_pos    = 0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (in_valid && !in_stall)
                predict_blur({in_red, in_green, in_blue});

            pending_results = expected_pixels.size();
        end
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives raster-order frames of many sizes into the four-neighbor blur,
// stalls both channels at random and judges the run from the checker's count.
// ----------------------------------------------------------------------------
module tb_top;
    import fnb_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PIXEL_GOAL   = 200;   // pixels in the random part
    localparam int CALM_TAIL    = 80;    // final pixels sent with no idling at all
    localparam int DRAIN_CYCLES = 8;     // margin after the last expected result
    localparam int NARROW_LIMIT = 40;    // widest frame of the random part

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic [CH_W-1:0]       in_red     = '0;
    logic [CH_W-1:0]       in_green   = '0;
    logic [CH_W-1:0]       in_blue    = '0;
    logic                  out_stall  = 1'b0;
    logic                  cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_stall;
    logic                  out_valid;
    logic [CH_W-1:0]       out_red;
    logic [CH_W-1:0]       out_green;
    logic [CH_W-1:0]       out_blue;
    logic                  run_last;
    logic                  frame_last;
    logic                  cfg_ready;
    int                    pending_results;
    int                    mismatch_count;

    // Percent chance that a side starts an idle burst: per cycle for results, per pixel for input
    int idle_pct    = 0;
    int stall_left  = 0;
    int pixels_sent = 0;
    int calm_mark   = 32'h7FFF_FFFF;
    // Raw register values last written, tracked so frames can be sized
    int frame_w     = WIDTH_RESET;
    int frame_h     = HEIGHT_RESET;

    // 4 x 3 frame: full-scale and zero neighbors around the two interior pixels
    pixel_t corner_frame [0:11] = '{
        24'h000000, 24'hFFFFFF, 24'h000000, 24'h7F80FF,
        24'hFFFFFF, 24'h123456, 24'hFFFFFF, 24'hFF00FF,
        24'h00FF01, 24'hFFFFFF, 24'h000000, 24'h80007F
    };

    four_neighbour_rgb_blur dut (.*);

    blur_checker blur_watch (.*);

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Hold the result channel off in bursts of random length
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 3);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    function automatic int pixels_per_frame();
        int cols;
        begin
            cols = (frame_w == 0) ? 1 : frame_w;
            if (cols > MAX_WIDTH)
                cols = MAX_WIDTH;
            return cols * ((frame_h == 0) ? 1 : frame_h);
        end
    endfunction

    // Mostly random content, with whole channels pinned to zero or full scale
    function automatic pixel_t random_pixel();
        pixel_t pix;
        begin
            pix = pixel_t'($urandom());
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                case ($urandom_range(0, 11))
                    0:       pix[ch*CH_W +: CH_W] = '0;
                    1:       pix[ch*CH_W +: CH_W] = '1;
                    default: ;
                endcase
            end
            return pix;
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic write_reg(input cfg_reg_t which, input int value);
        begin
            cfg_valid = 1'b1;
            cfg_index = which;
            cfg_data  = value[CFG_DATA_W-1:0];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
            cfg_valid = 1'b0;
            if (which == REG_IMAGE_WIDTH)
                frame_w = value;
            else
                frame_h = value;
        end
    endtask

    // Called at a falling edge; leaves in_valid high for a back-to-back transfer
    task automatic send_pixel(input pixel_t pix);
        begin
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                in_valid = 1'b0;
                repeat ($urandom_range(1, 4))
                    @(negedge clk);
            end
            in_valid = 1'b1;
            in_red   = pix[2*CH_W +: CH_W];
            in_green = pix[CH_W +: CH_W];
            in_blue  = pix[0 +: CH_W];
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            @(negedge clk);
            pixels_sent++;
        end
    endtask

    task automatic stream_pixels(input int count);
        begin
            for (int i = 0; i < count; i++)
            begin
                if (pixels_sent >= calm_mark)
                    idle_pct = 0;
                send_pixel(random_pixel());
            end
        end
    endtask

    // Drop valid, let every expected result arrive, then let first-row pixels
    // (which release nothing) clear the pipeline before any register write
    task automatic wait_drained();
        begin
            in_valid = 1'b0;
            while (pending_results != 0)
                @(negedge clk);
            repeat (DRAIN_CYCLES)
                @(negedge clk);
        end
    endtask

    initial
    begin
        #(CYCLE_LIMIT * CLK_PERIOD);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int goal_mark;
        int new_w;
        int new_h;

        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Small frame with interior pixels; extreme channel values
        idle_pct = 20;
        write_reg(REG_IMAGE_WIDTH, 4);
        write_reg(REG_IMAGE_HEIGHT, 3);
        foreach (corner_frame[i])
            send_pixel(corner_frame[i]);

        // Zero width and zero height both count as one: two 1 x 1 frames
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 0);
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);

        // Narrow frame: everything is border
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, 2);
        write_reg(REG_IMAGE_HEIGHT, 2);
        stream_pixels(4);

        // Tallest frame, abandoned mid-frame; the next write restarts it
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, 3);
        write_reg(REG_IMAGE_HEIGHT, 65535);
        stream_pixels(4);

        // Single-row frame passes straight through
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, 5);
        write_reg(REG_IMAGE_HEIGHT, 1);
        stream_pixels(5);

        // Widest register value clamps to the line store depth; wrap into row 1
        wait_drained();
        idle_pct = 10;
        write_reg(REG_IMAGE_WIDTH, 2047);
        write_reg(REG_IMAGE_HEIGHT, 2);
        stream_pixels(MAX_WIDTH + 8);

        // Random part: whole frames of small random size, now and then cut short
        goal_mark = pixels_sent + PIXEL_GOAL;
        calm_mark = goal_mark - CALM_TAIL;
        while (pixels_sent < goal_mark)
        begin
            wait_drained();
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 10;
                default: idle_pct = 35;
            endcase
            if (pixels_sent >= calm_mark)
                idle_pct = 0;

            case ($urandom_range(0, 9))
                0:       new_w = $urandom_range(13, NARROW_LIMIT);
                1:       new_w = $urandom_range(0, 2);
                default: new_w = $urandom_range(3, 12);
            endcase
            case ($urandom_range(0, 7))
                0:       new_h = $urandom_range(0, 1);
                default: new_h = $urandom_range(2, 6);
            endcase

            if (frame_w > NARROW_LIMIT || frame_h > 6 || $urandom_range(0, 1) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    write_reg(REG_IMAGE_WIDTH, new_w);
                    write_reg(REG_IMAGE_HEIGHT, new_h);
                end
                else
                begin
                    write_reg(REG_IMAGE_HEIGHT, new_h);
                    write_reg(REG_IMAGE_WIDTH, new_w);
                end
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                write_reg(REG_IMAGE_WIDTH, new_w);
            end
            else
            begin
                write_reg(REG_IMAGE_HEIGHT, new_h);
            end

            stream_pixels($urandom_range(1, 3) * pixels_per_frame());
            if ($urandom_range(0, 4) == 0 && pixels_per_frame() > 1)
                stream_pixels($urandom_range(1, pixels_per_frame() - 1));
        end

        wait_drained();
        if (mismatch_count == 0 && pending_results == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
